/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, off while reset is high.
`define ASSERT_ON(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ssh_pkg.sv */
// Shared constants, codes, material table and rounding for the slope shader.
package ssh_pkg;

  // Fraction bits of the vector and color format
  localparam int VEC_FRAC_BITS = 14;
  localparam int QONE = 1 << VEC_FRAC_BITS;
  localparam int QB = VEC_FRAC_BITS + 1;

  // Word widths
  localparam int IN_W = 120;
  localparam int OUT_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Squared-length widths fed to the root units (even)
  localparam int PSQ_W = 48;
  localparam int RSQ_W = 40;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (VEC_FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SNOW_TH = 3'd0,
    CFG_DIRT_TH = 3'd1,
    CFG_LIGHT_X = 3'd2,
    CFG_LIGHT_Y = 3'd3,
    CFG_LIGHT_Z = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MAT_SNOW  = 2'd0,
    MAT_GRASS = 2'd1,
    MAT_DIRT  = 2'd2
  } mat_t;

  // Register reset values
  localparam int SNOW_TH_RST = (85 * QONE * 2 + 100) / 200;
  localparam int DIRT_TH_RST = (55 * QONE * 2 + 100) / 200;
  localparam int LIGHT_A = (57735 * QONE * 2 + 100000) / 200000;

  // Material constants, rounded to nearest
  localparam int AMB_SNOW  = (7 * QONE * 2 + 10) / 20;
  localparam int AMB_OTHER = (3 * QONE * 2 + 10) / 20;
  localparam int DIF_LOW   = QONE / 2;
  localparam int DIF_DIRT  = (7 * QONE * 2 + 10) / 20;
  localparam int SPE_SNOW  = QONE / 2;
  localparam int SPE_GRASS = (2 * QONE * 2 + 10) / 20;
  localparam int COL_SNOW  = (95 * QONE * 2 + 100) / 200;
  localparam int COL_G_R   = (9 * QONE * 2 + 100) / 200;
  localparam int COL_G_G   = (3 * QONE * 2 + 10) / 20;
  localparam int COL_G_B   = (3 * QONE * 2 + 100) / 200;
  localparam int COL_D_R   = (27 * QONE * 2 + 100) / 200;
  localparam int COL_D_G   = (24 * QONE * 2 + 100) / 200;
  localparam int COL_D_B   = (QONE * 2 + 10) / 20;

  // Round to nearest back to the fraction format (floor after half LSB)
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    return (v + HALF) >>> VEC_FRAC_BITS;
  endfunction

  // Ambient term times color, rounded, worked out at elaboration
  function automatic int amb_col_c(input int amb, input int col);
    return (amb * col + QONE / 2) >> VEC_FRAC_BITS;
  endfunction

  function automatic logic [14:0] mat_dif(input logic [1:0] m);
    logic [14:0] d;
    d = (m == MAT_DIRT) ? 15'(DIF_DIRT) : 15'(DIF_LOW);
    return d;
  endfunction

  function automatic logic [14:0] mat_spe(input logic [1:0] m);
    logic [14:0] s;
    unique case (m)
      MAT_SNOW:  s = 15'(SPE_SNOW);
      MAT_GRASS: s = 15'(SPE_GRASS);
      default:   s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [14:0] mat_col(input logic [1:0] m, input int ch);
    logic [14:0] c;
    unique case (m)
      MAT_SNOW:  c = 15'(COL_SNOW);
      MAT_GRASS: c = (ch == 0) ? 15'(COL_G_R) : (ch == 1) ? 15'(COL_G_G) : 15'(COL_G_B);
      default:   c = (ch == 0) ? 15'(COL_D_R) : (ch == 1) ? 15'(COL_D_G) : 15'(COL_D_B);
    endcase
    return c;
  endfunction

  function automatic logic [13:0] mat_amb_col(input logic [1:0] m, input int ch);
    logic [13:0] a;
    unique case (m)
      MAT_SNOW:  a = 14'(amb_col_c(AMB_SNOW, COL_SNOW));
      MAT_GRASS: a = (ch == 0) ? 14'(amb_col_c(AMB_OTHER, COL_G_R)) :
                     (ch == 1) ? 14'(amb_col_c(AMB_OTHER, COL_G_G)) :
                                 14'(amb_col_c(AMB_OTHER, COL_G_B));
      default:   a = (ch == 0) ? 14'(amb_col_c(AMB_OTHER, COL_D_R)) :
                     (ch == 1) ? 14'(amb_col_c(AMB_OTHER, COL_D_G)) :
                                 14'(amb_col_c(AMB_OTHER, COL_D_B));
    endcase
    return a;
  endfunction

endpackage

/* sv/ssh_delay.sv */
// Enabled shift line that carries side data alongside the long units.
module ssh_delay #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  logic [W-1:0] sr [D];

  // Advance every tap together
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int k = 1; k < D; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign dout = sr[D-1];
endmodule

/* sv/ssh_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
module ssh_isqrt #(
  parameter int W = 48
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   rad,
  output logic [W/2-1:0] root
);
  localparam int H = W / 2;
  localparam int RW = H + 3;

  logic [W-1:0]    v_in   [H];
  logic [RW-3:0]   rem_in [H];
  logic [H-1:0]    rt_in  [H];
  logic [W-1:0]    v_q    [H];
  logic [RW-3:0]   rem_q  [H];
  logic [H-1:0]    rt_q   [H];

  assign v_in[0] = rad;
  assign rem_in[0] = '0;
  assign rt_in[0] = '0;

  for (genvar k = 1; k < H; k++) begin : g_link
    assign v_in[k] = v_q[k-1];
    assign rem_in[k] = rem_q[k-1];
    assign rt_in[k] = rt_q[k-1];
  end

  for (genvar k = 0; k < H; k++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_nx;
    logic          ge;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_in[k], v_in[k][W-1 -: 2]};
      trial = RW'({rt_in[k], 2'b01});
      ge = (rem_sh >= trial);
      rem_nx = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[k] <= v_in[k] << 2;
        rem_q[k] <= rem_nx[RW-3:0];
        rt_q[k] <= {rt_in[k][H-2:0], ge};
      end
    end
  end

  assign root = rt_q[H-1];
endmodule

/* sv/ssh_div.sv */
// Pipelined signed divide: trunc(a * 2^F / m) with |a| <= m, one bit per stage.
module ssh_div #(
  parameter int AW = 24,
  parameter int MW = 24,
  parameter int QW = 15
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [AW-1:0] a,
  input  logic [MW-1:0]        m,
  output logic signed [QW:0]   q
);
  logic [MW:0]   r_in  [QW];
  logic [QW-1:0] q_in  [QW];
  logic [MW-1:0] m_in  [QW];
  logic          ng_in [QW];
  logic          z_in  [QW];
  logic [MW:0]   r_q   [QW];
  logic [QW-1:0] q_q   [QW];
  logic [MW-1:0] m_q   [QW];
  logic          ng_q  [QW];
  logic          z_q   [QW];
  logic [AW-1:0] mag;

  assign mag = a[AW-1] ? AW'(-a) : AW'(a);
  assign r_in[0] = (MW+1)'(mag);
  assign q_in[0] = '0;
  assign m_in[0] = m;
  assign ng_in[0] = a[AW-1];
  assign z_in[0] = (m == '0);

  for (genvar k = 1; k < QW; k++) begin : g_link
    assign r_in[k] = r_q[k-1];
    assign q_in[k] = q_q[k-1];
    assign m_in[k] = m_q[k-1];
    assign ng_in[k] = ng_q[k-1];
    assign z_in[k] = z_q[k-1];
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [MW:0] rt;
    logic [MW:0] r_nx;
    logic        ge;

    // Shift the remainder (all but the first stage), then subtract the divisor where it fits
    always_comb begin
      if (k == 0) begin
        rt = r_in[k];
      end else begin
        rt = {r_in[k][MW-1:0], 1'b0};
      end
      ge = (rt >= {1'b0, m_in[k]});
      r_nx = ge ? (rt - {1'b0, m_in[k]}) : rt;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k] <= r_nx;
        q_q[k] <= {q_in[k][QW-2:0], ge};
        m_q[k] <= m_in[k];
        ng_q[k] <= ng_in[k];
        z_q[k] <= z_in[k];
      end
    end
  end

  // Apply sign; a zero divisor yields zero
  always_ff @(posedge clk) begin
    if (en) begin
      if (z_q[QW-1]) begin
        q <= '0;
      end else if (ng_q[QW-1]) begin
        q <= -$signed({1'b0, q_q[QW-1]});
      end else begin
        q <= $signed({1'b0, q_q[QW-1]});
      end
    end
  end
endmodule

/* sv/slope_material_phong_shader.sv */
// Top level: slope-picked material with ambient, diffuse and specular shading.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_tvalid/s_tready  | s_tdata: normal_x,y,z (16b), pos_x,y,z (24b)
//   m_      | out       | m_tvalid/m_tready  | m_tdata: red, green, blue (15b), material (2b)
//   cfg_    | in        | cfg_wr_en          | cfg_index, cfg_data
//
// One word enters per cycle while s_tready is high; m_tvalid rises once the word has passed every stage.
// Most of the depth comes from the position square root (24 stages) and the dividers (16).
// Reset (synchronous) clears all valid bits and loads the default thresholds and light.
// When the output word waits and the last stage holds a word, every stage holds.
// A bubble in the last stage lets the pipeline advance while the output waits.
`include "assert_macros.svh"

module slope_material_phong_shader (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // normal_x[15:0] normal_y[31:16] normal_z[47:32] pos_x[71:48] pos_y[95:72] pos_z[119:96]
  input  logic [ssh_pkg::IN_W-1:0]         s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // red[14:0] green[29:15] blue[44:30] material[46:45], bit 47 zero
  output logic [ssh_pkg::OUT_W-1:0]        m_tdata,
  input  logic                             cfg_wr_en,
  input  logic [ssh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssh_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ssh_pkg::*;

  localparam int ST_SQ = 2 + PSQ_W / 2;
  localparam int ST_Q = ST_SQ + QB + 1;
  localparam int P_DLY = ST_SQ;
  localparam int R_DLY = ST_SQ - 4;
  localparam int SIDE_DLY = ST_Q;
  localparam int NS = ST_Q + 7;

  // Configuration registers
  logic [14:0]        snow_th;
  logic [14:0]        dirt_th;
  logic signed [15:0] light [3];

  // Flow control
  logic          en;
  logic          ld;
  logic [NS-1:0] v_q;
  logic          out_v;

  // Stage registers
  logic signed [15:0] n0 [3];
  logic signed [23:0] p0 [3];
  logic signed [31:0] ln1 [3];
  logic [46:0]        pp1 [3];
  logic signed [15:0] n1 [3];
  logic [1:0]         code1;
  logic signed [16:0] dot2;
  logic [47:0]        psum2;
  logic signed [15:0] n2 [3];
  logic [1:0]         code2;
  logic signed [33:0] dn3 [3];
  logic [16:0]        d23;
  logic [1:0]         code3;
  logic signed [18:0] r4 [3];
  logic [18:0]        d4a4;
  logic [1:0]         code4;
  logic [35:0]        rr5 [3];
  logic [18:0]        d45;
  logic [1:0]         code5;
  logic [37:0]        rsum6;
  logic signed [31:0] cr43 [3];
  logic [14:0]        cc44;
  logic               cpos44;
  logic [14:0]        c245;
  logic [14:0]        cc45;
  logic               cpos45;
  logic [14:0]        c446;
  logic [14:0]        cc46;
  logic               cpos46;
  logic [14:0]        c547;
  logic               cpos47;
  logic [13:0]        spec48;
  logic [17:0]        dc48 [3];
  logic [1:0]         code48;
  logic [14:0]        col_out [3];
  logic [1:0]         mat_out;

  // Unit outputs and side data
  logic [23:0]        mp;
  logic [19:0]        mr;
  logic [71:0]        p_dly;
  logic [56:0]        r_dly;
  logic [20:0]        side_dly;
  logic [1:0]         code47;
  logic [18:0]        d447;
  logic signed [QB:0] cu [3];
  logic signed [QB:0] ru [3];

  // Next values
  logic signed [31:0] ln_next [3];
  logic signed [47:0] pp_full [3];
  logic [1:0]         code_next;
  logic signed [63:0] lsum;
  logic signed [63:0] dot_r;
  logic signed [16:0] dot_next;
  logic [47:0]        psum_next;
  logic signed [33:0] dn_next [3];
  logic signed [33:0] dsq;
  logic [16:0]        d2_next;
  logic signed [18:0] r_next [3];
  logic [33:0]        d2sq;
  logic [18:0]        d4a_next;
  logic signed [37:0] rsq [3];
  logic [33:0]        d4p;
  logic [18:0]        d4_next;
  logic [37:0]        rsum_next;
  logic signed [63:0] csum;
  logic signed [63:0] cos_r;
  logic [14:0]        cc_next;
  logic [29:0]        c2p;
  logic [29:0]        c4p;
  logic [29:0]        c5p;
  logic [29:0]        spp;
  logic [13:0]        spec_next;
  logic [33:0]        dcp [3];
  logic [17:0]        dc_next [3];
  logic [18:0]        csat [3];

  // Flow: the output stage loads when free or taken, the rest moves unless it would drop
  assign ld = !out_v || m_tready;
  assign en = ld || !v_q[NS-1];
  assign s_tready = en;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      snow_th <= 15'(SNOW_TH_RST);
      dirt_th <= 15'(DIRT_TH_RST);
      light[0] <= -16'(LIGHT_A);
      light[1] <= 16'(LIGHT_A);
      light[2] <= -16'(LIGHT_A);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SNOW_TH: snow_th <= cfg_data[14:0];
        CFG_DIRT_TH: dirt_th <= cfg_data[14:0];
        CFG_LIGHT_X: light[0] <= cfg_data;
        CFG_LIGHT_Y: light[1] <= cfg_data;
        CFG_LIGHT_Z: light[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], s_tvalid};
    end
  end

  // Front stages: dot product, material, squared lengths, reflection
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ln_next[i] = light[i] * n0[i];
      pp_full[i] = p0[i] * p0[i];
    end
    if ($signed({n0[1][15], n0[1]}) >= $signed({2'b00, snow_th})) begin
      code_next = MAT_SNOW;
    end else if ($signed({n0[1][15], n0[1]}) <= $signed({2'b00, dirt_th})) begin
      code_next = MAT_DIRT;
    end else begin
      code_next = MAT_GRASS;
    end

    lsum = 64'(ln1[0]) + 64'(ln1[1]) + 64'(ln1[2]);
    dot_r = rnd(lsum);
    if (dot_r > 64'(2 * QONE)) begin
      dot_next = 17'(2 * QONE);
    end else if (dot_r < -64'(2 * QONE)) begin
      dot_next = -17'(2 * QONE);
    end else begin
      dot_next = dot_r[16:0];
    end
    psum_next = 48'(pp1[0]) + 48'(pp1[1]) + 48'(pp1[2]);

    for (int i = 0; i < 3; i++) begin
      dn_next[i] = (dot2 * n2[i]) <<< 1;
    end
    dsq = dot2 * dot2;
    d2_next = dot2[16] ? '0 : 17'(rnd(64'(dsq)));

    for (int i = 0; i < 3; i++) begin
      r_next[i] = 19'(64'(light[i]) - rnd(64'(dn3[i])));
    end
    d2sq = d23 * d23;
    d4a_next = 19'(rnd(64'(d2sq)));

    for (int i = 0; i < 3; i++) begin
      rsq[i] = r4[i] * r4[i];
    end
    d4p = 34'(d4a4) * 34'(mat_dif(code4));
    d4_next = 19'(rnd(64'(d4p)));

    rsum_next = 38'(rr5[0]) + 38'(rr5[1]) + 38'(rr5[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n0[i] <= s_tdata[16*i +: 16];
        p0[i] <= s_tdata[48 + 24*i +: 24];
        ln1[i] <= ln_next[i];
        pp1[i] <= pp_full[i][46:0];
        n1[i] <= n0[i];
        n2[i] <= n1[i];
        dn3[i] <= dn_next[i];
        r4[i] <= r_next[i];
        rr5[i] <= rsq[i][35:0];
      end
      code1 <= code_next;
      dot2 <= dot_next;
      psum2 <= psum_next;
      code2 <= code1;
      d23 <= d2_next;
      code3 <= code2;
      d4a4 <= d4a_next;
      code4 <= code3;
      d45 <= d4_next;
      code5 <= code4;
      rsum6 <= rsum_next;
    end
  end

  // Square roots of both squared lengths, finishing in the same stage
  ssh_isqrt #(.W(PSQ_W)) u_sqrt_p (
    .clk(clk), .en(en), .rad(psum2), .root(mp)
  );

  ssh_isqrt #(.W(RSQ_W)) u_sqrt_r (
    .clk(clk), .en(en), .rad(RSQ_W'(rsum6)), .root(mr)
  );

  // Hold vectors and material data until their units finish
  ssh_delay #(.W(72), .D(P_DLY)) u_dly_p (
    .clk(clk), .en(en), .din({p0[2], p0[1], p0[0]}), .dout(p_dly)
  );

  ssh_delay #(.W(57), .D(R_DLY)) u_dly_r (
    .clk(clk), .en(en), .din({r4[2], r4[1], r4[0]}), .dout(r_dly)
  );

  ssh_delay #(.W(21), .D(SIDE_DLY)) u_dly_side (
    .clk(clk), .en(en), .din({code5, d45}), .dout(side_dly)
  );

  assign code47 = side_dly[20:19];
  assign d447 = side_dly[18:0];

  // Normalize position and reflection
  for (genvar i = 0; i < 3; i++) begin : g_norm
    ssh_div #(.AW(24), .MW(24), .QW(QB)) u_div_p (
      .clk(clk), .en(en), .a(p_dly[24*i +: 24]), .m(mp), .q(cu[i])
    );
    ssh_div #(.AW(19), .MW(20), .QW(QB)) u_div_r (
      .clk(clk), .en(en), .a(r_dly[19*i +: 19]), .m(mr), .q(ru[i])
    );
  end

  // Back stages: cosine, its fifth power, terms and saturation
  always_comb begin
    csum = 64'(cr43[0]) + 64'(cr43[1]) + 64'(cr43[2]);
    cos_r = rnd(csum);
    cc_next = (cos_r > 64'(QONE)) ? 15'(QONE) : cos_r[14:0];
    c2p = cc44 * cc44;
    c4p = c245 * c245;
    c5p = c446 * cc46;
    spp = c547 * mat_spe(code47);
    spec_next = cpos47 ? 14'(rnd(64'(spp))) : '0;
    for (int i = 0; i < 3; i++) begin
      dcp[i] = 34'(d447) * 34'(mat_col(code47, i));
      dc_next[i] = 18'(rnd(64'(dcp[i])));
      csat[i] = 19'(mat_amb_col(code48, i)) + 19'(dc48[i]) + 19'(spec48);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cr43[i] <= cu[i] * ru[i];
        dc48[i] <= dc_next[i];
      end
      cc44 <= cc_next;
      cpos44 <= (cos_r > 64'sd0);
      c245 <= 15'(rnd(64'(c2p)));
      cc45 <= cc44;
      cpos45 <= cpos44;
      c446 <= 15'(rnd(64'(c4p)));
      cc46 <= cc45;
      cpos46 <= cpos45;
      c547 <= 15'(rnd(64'(c5p)));
      cpos47 <= cpos46;
      spec48 <= spec_next;
      code48 <= code47;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (ld) begin
      out_v <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      for (int i = 0; i < 3; i++) begin
        col_out[i] <= (csat[i] > 19'd32767) ? 15'h7FFF : csat[i][14:0];
      end
      mat_out <= code48;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata = {1'b0, mat_out, col_out[2], col_out[1], col_out[0]};

  `ASSERT_ON(a_accept_enters, clk, rst, s_tvalid && s_tready |=> v_q[0], "taken word missing in first stage")
  `ASSERT_ON(a_stall_holds, clk, rst, !en |=> $stable(v_q), "pipeline moved during a stall")
  `ASSERT_ON(a_dirt_no_spec, clk, rst, v_q[NS-1] && code48 == MAT_DIRT |-> spec48 == '0, "dirt got a highlight")
endmodule
